### src/per_port_packet_ring_buffers_core_defines.svh
// assertion macros shared by the rtl
`ifndef PER_PORT_PACKET_RING_BUFFERS_CORE_DEFINES_SVH
`define PER_PORT_PACKET_RING_BUFFERS_CORE_DEFINES_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

### src/pprb_pkg.sv
package pprb_pkg;

   localparam int NUM_QUEUES_DEF  = 8;
   localparam int QUEUE_BYTES_DEF = 1024;

   localparam int OP_W       = 2;
   localparam int PORT_W     = 3;
   localparam int LEN_W      = 11;
   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int FILL_OUT_W = 11;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [OP_W-1:0] {
      OP_START = 2'd0,
      OP_DATA  = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_DROP  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_DELIVER
   } state_type;

endpackage

### src/per_port_packet_ring_buffers_core.sv
// channel | dir | tdata (low bit up)                              | tuser
// req     | in  | port[2:0] packet_length[13:3] data_byte[21:14]  | operation[1:0]
// rsp     | out | read_byte[7:0] fill_level[18:8]                 | status[1:0]
//
// every item passes through accept (queue state memory read), lookup
// (state write-back and byte store access) and deliver (result register load);
// the queue state memory read and the byte store read are both registered
// reset clears queue heads and fills at once through per-queue valid bits,
// no clearing pass; the byte store is not cleared
// a stalled result holds in deliver; no new beat is taken until it moves
`include "per_port_packet_ring_buffers_core_defines.svh"

module per_port_packet_ring_buffers_core #(
   parameter int NUM_QUEUES  = pprb_pkg::NUM_QUEUES_DEF,
   parameter int QUEUE_BYTES = pprb_pkg::QUEUE_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // port[2:0], packet_length[13:3], data_byte[21:14], zero pad
   input  logic [pprb_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [pprb_pkg::OP_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_byte[7:0], fill_level[18:8], zero pad
   output logic [pprb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [pprb_pkg::STATUS_W-1:0]   rsp_tuser
);
   import pprb_pkg::*;

   localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int HW    = $clog2(QUEUE_BYTES);
   localparam int FW    = $clog2(QUEUE_BYTES + 1);
   localparam int DEPTH = NUM_QUEUES * QUEUE_BYTES;
   localparam int AW    = $clog2(DEPTH);
   localparam int RSP_PAD_W = RSP_DATA_W - FILL_OUT_W - BYTE_W;

   // control state
   state_type state_ff, state_in;
   logic [PORT_W-1:0] open_port_ff, open_port_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // captured beat
   logic [OP_W-1:0]   op_ff;
   logic [PORT_W-1:0] port_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic [QW-1:0]     qidx_ff;

   // queue state memory: {fill, head} per queue, valid bit means written since reset
   logic [HW+FW-1:0]      qmem [NUM_QUEUES];
   logic [HW+FW-1:0]      qrd_ff;
   logic [NUM_QUEUES-1:0] qvalid_ff;
   logic                  qvld_rd_ff;

   // pending result from lookup
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [FILL_OUT_W-1:0] res_fill_ff, res_fill_in;
   logic                  res_rd_ok_ff, res_rd_ok_in;

   // output register
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [BYTE_W-1:0]     rsp_byte_ff;
   logic [FILL_OUT_W-1:0] rsp_fill_ff;

   // request fields
   logic [PORT_W-1:0]   req_port;
   logic [LEN_W-1:0]    req_len;
   logic [BYTE_W-1:0]   req_byte;
   logic [PORT_W-1:0]   rd_port;
   logic [PORT_W+3:0]   rd_port_wide;
   logic [QW-1:0]       rd_idx;
   logic                req_accept;
   logic                out_free;

   // lookup datapath
   logic [HW-1:0] cur_head;
   logic [FW-1:0] cur_fill;
   logic          port_ok;
   logic [31:0]   sum32, pos32, base32, head_inc32, start_sum32;
   logic          qwr_en;
   logic [HW-1:0] qwr_head;
   logic [FW-1:0] qwr_fill;
   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   function automatic logic [FILL_OUT_W-1:0] fill_low(input logic [FW-1:0] f);
      logic [31:0] w;
      w = 32'(f);
      return w[FILL_OUT_W-1:0];
   endfunction

   assign req_port   = req_tdata[PORT_W-1:0];
   assign req_len    = req_tdata[PORT_W+LEN_W-1:PORT_W];
   assign req_byte   = req_tdata[PORT_W+LEN_W+BYTE_W-1:PORT_W+LEN_W];
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // a data beat works on the open queue, others on the named port
   assign rd_port      = (req_tuser == OP_DATA) ? open_port_ff : req_port;
   assign rd_port_wide = {4'b0000, rd_port};
   assign rd_idx       = rd_port_wide[QW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_DELIVER;
         end
         S_DELIVER: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   // lookup: decide, update queue state, touch the byte store
   always_comb begin
      cur_head    = qvld_rd_ff ? qrd_ff[HW-1:0] : '0;
      cur_fill    = qvld_rd_ff ? qrd_ff[HW+FW-1:HW] : '0;
      port_ok     = (32'(port_ff) < 32'(NUM_QUEUES));
      sum32       = 32'(cur_head) + 32'(cur_fill);
      pos32       = (sum32 >= 32'(QUEUE_BYTES)) ? (sum32 - 32'(QUEUE_BYTES)) : sum32;
      base32      = 32'(qidx_ff) * 32'(QUEUE_BYTES);
      head_inc32  = 32'(cur_head) + 32'd1;
      start_sum32 = 32'(cur_fill) + 32'(len_ff);

      res_status_in = STAT_DROP;
      res_fill_in   = '0;
      res_rd_ok_in  = 1'b0;
      qwr_en        = 1'b0;
      qwr_head      = cur_head;
      qwr_fill      = cur_fill;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_addr      = AW'(base32 + pos32);
      open_port_in  = open_port_ff;
      rem_in        = rem_ff;

      if (state_ff == S_LOOKUP) begin
         case (op_ff)
            OP_START: begin
               rem_in = '0;
               if (!port_ok) begin
                  res_status_in = STAT_DROP;
               end else if (start_sum32 > 32'(QUEUE_BYTES)) begin
                  res_status_in = STAT_DROP;
                  res_fill_in   = fill_low(cur_fill);
               end else begin
                  res_status_in = STAT_OK;
                  res_fill_in   = fill_low(cur_fill);
                  open_port_in  = port_ff;
                  rem_in        = len_ff;
               end
            end
            OP_DATA: begin
               if (rem_ff == '0 || 32'(cur_fill) >= 32'(QUEUE_BYTES)) begin
                  res_status_in = STAT_DROP;
                  res_fill_in   = fill_low(cur_fill);
               end else begin
                  ram_wr_en     = 1'b1;
                  qwr_en        = 1'b1;
                  qwr_fill      = cur_fill + FW'(1);
                  rem_in        = rem_ff - LEN_W'(1);
                  res_status_in = STAT_OK;
                  res_fill_in   = fill_low(qwr_fill);
               end
            end
            OP_READ: begin
               if (!port_ok || cur_fill == '0) begin
                  res_status_in = STAT_EMPTY;
               end else begin
                  ram_rd_en     = 1'b1;
                  ram_addr      = AW'(base32 + 32'(cur_head));
                  qwr_en        = 1'b1;
                  qwr_head      = (head_inc32 == 32'(QUEUE_BYTES)) ? '0 : head_inc32[HW-1:0];
                  qwr_fill      = cur_fill - FW'(1);
                  res_status_in = STAT_OK;
                  res_fill_in   = fill_low(qwr_fill);
                  res_rd_ok_in  = 1'b1;
               end
            end
            default: begin
               res_status_in = STAT_DROP;
            end
         endcase
      end
   end

   // output register: loads in deliver, drains when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == S_DELIVER && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         open_port_ff <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         qvalid_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         open_port_ff <= open_port_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
         if (qwr_en) begin
            qvalid_ff[qidx_ff] <= 1'b1;
         end
      end
   end

   // beat capture, queue state memory read and queue state write-back
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff      <= req_tuser;
         port_ff    <= req_port;
         len_ff     <= req_len;
         byte_ff    <= req_byte;
         qidx_ff    <= rd_idx;
         qrd_ff     <= qmem[rd_idx];
         qvld_rd_ff <= qvalid_ff[rd_idx];
      end
      if (qwr_en) begin
         qmem[qidx_ff] <= {qwr_fill, qwr_head};
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_LOOKUP) begin
         res_status_ff <= res_status_in;
         res_fill_ff   <= res_fill_in;
         res_rd_ok_ff  <= res_rd_ok_in;
      end
      if (state_ff == S_DELIVER && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_fill_ff   <= res_fill_ff;
         rsp_byte_ff   <= res_rd_ok_ff ? ram_rd_data : '0;
      end
   end

   pprb_byte_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data (byte_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_fill_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_status_ff;

   `ASSERT_NEXT(a_accept_to_lookup, clock, reset, req_accept, state_ff == S_LOOKUP)
   `ASSERT_NEXT(a_lookup_to_deliver, clock, reset, state_ff == S_LOOKUP, state_ff == S_DELIVER)
   `ASSERT_IMPLY(a_fill_bound, clock, reset, qwr_en, 32'(qwr_fill) <= 32'(QUEUE_BYTES))
   `ASSERT_IMPLY(a_open_port_ok, clock, reset, rem_ff != '0, 32'(open_port_ff) < 32'(NUM_QUEUES))
   `ASSERT_IMPLY(a_byte_only_on_ok, clock, reset, rsp_valid_ff && rsp_status_ff != STAT_OK, rsp_byte_ff == '0)

endmodule

### src/pprb_byte_ram.sv
module pprb_byte_ram #(
   parameter int DEPTH = pprb_pkg::NUM_QUEUES_DEF * pprb_pkg::QUEUE_BYTES_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic                        rd_en,
   input  logic [AW-1:0]               addr,
   input  logic [pprb_pkg::BYTE_W-1:0] wr_data,
   output logic [pprb_pkg::BYTE_W-1:0] rd_data
);
   import pprb_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // single port, read data held until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
